// File: rtl/utt_pkg.sv
// Shared types, constants and the UTF-8 byte builder for the UTF-16 to UTF-8 transcoder.
`default_nettype none

package utt_pkg;

    // Largest number of result bytes one code unit can cause
    localparam int unsigned NUM_SLOTS = 5;
    localparam int unsigned CNT_W     = 3;

    // Surrogate ranges and the supplementary plane offset
    localparam logic [15:0] LOW_SUR_MIN  = 16'hDC00;
    localparam logic [15:0] LOW_SUR_MAX  = 16'hDFFF;
    localparam logic [15:0] HIGH_SUR_MIN = 16'hD800;
    localparam logic [15:0] HIGH_SUR_MAX = 16'hDBFF;
    localparam logic [20:0] SUPP_BASE    = 21'h10000;

    // Encoding length boundaries
    localparam logic [20:0] ONE_BYTE_LIMIT   = 21'h80;
    localparam logic [20:0] TWO_BYTE_LIMIT   = 21'h800;
    localparam logic [20:0] THREE_BYTE_LIMIT = 21'h10000;

    // Carried string state
    typedef struct packed {
        logic [9:0] held_high_bits;
        logic       high_pending;
        logic       string_finished;
    } utt_state_t;

    // Result burst for one code unit; slot 0 goes out first
    typedef struct packed {
        logic [NUM_SLOTS-1:0][7:0] bytes;
        logic [NUM_SLOTS-1:0]      err;
        logic [NUM_SLOTS-1:0]      term;
        logic [CNT_W-1:0]          count;
    } utt_burst_t;

    // UTF-8 bytes of one code point, lead byte in element 0
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
    } utt_enc_t;

    function automatic utt_enc_t utt_encode(input logic [20:0] cp);
        utt_enc_t e;
        e = '0;
        if (cp < ONE_BYTE_LIMIT) begin
            e.bytes[0] = {1'b0, cp[6:0]};
            e.count    = 3'd1;
        end else if (cp < TWO_BYTE_LIMIT) begin
            e.bytes[0] = {3'b110, cp[10:6]};
            e.bytes[1] = {2'b10, cp[5:0]};
            e.count    = 3'd2;
        end else if (cp < THREE_BYTE_LIMIT) begin
            e.bytes[0] = {4'b1110, cp[15:12]};
            e.bytes[1] = {2'b10, cp[11:6]};
            e.bytes[2] = {2'b10, cp[5:0]};
            e.count    = 3'd3;
        end else begin
            e.bytes[0] = {5'b11110, cp[20:18]};
            e.bytes[1] = {2'b10, cp[17:12]};
            e.bytes[2] = {2'b10, cp[11:6]};
            e.bytes[3] = {2'b10, cp[5:0]};
            e.count    = 3'd4;
        end
        return e;
    endfunction

endpackage

`default_nettype wire

// File: rtl/utt_decode.sv
// Combinational decode of one code unit into a result burst and the next string state.
`default_nettype none

module utt_decode
    import utt_pkg::*;
(
    input  wire logic [15:0] unit,
    input  wire logic        fin,
    input  wire utt_state_t  state,
    output utt_burst_t       burst,
    output utt_state_t       state_next
);

    logic     is_low;
    logic     is_high;
    logic [20:0] pair_cp;
    logic [20:0] cp;
    utt_enc_t enc;
    logic     use_enc;
    logic     tail_err;
    logic     tail_term;
    logic     ended;
    logic [2:0] nb;

    assign is_low  = (unit >= LOW_SUR_MIN) && (unit <= LOW_SUR_MAX);
    assign is_high = (unit >= HIGH_SUR_MIN) && (unit <= HIGH_SUR_MAX);
    assign pair_cp = {1'b0, state.held_high_bits, unit[9:0]} + SUPP_BASE;
    assign cp      = state.high_pending ? pair_cp : {5'd0, unit};
    assign enc     = utt_encode(cp);

    // Classify the unit against the carried state
    always_comb
    begin
        use_enc    = 1'b0;
        tail_err   = 1'b0;
        ended      = 1'b0;
        state_next = state;
        if (state.string_finished) begin
            if (fin) begin
                state_next = '0;
            end
        end else begin
            state_next.high_pending   = 1'b0;
            state_next.held_high_bits = '0;
            if (state.high_pending) begin
                if (is_low) begin
                    use_enc = 1'b1;
                end else begin
                    tail_err = 1'b1;
                    ended    = 1'b1;
                end
            end else if (unit == 16'd0) begin
                ended = 1'b1;
            end else if (is_low) begin
                tail_err = 1'b1;
                ended    = 1'b1;
            end else if (is_high) begin
                if (fin) begin
                    tail_err = 1'b1;
                    ended    = 1'b1;
                end else begin
                    state_next.high_pending   = 1'b1;
                    state_next.held_high_bits = unit[9:0];
                end
            end else begin
                use_enc = 1'b1;
            end
            state_next.string_finished = (ended || fin) && !fin;
        end
    end

    // Terminator or error goes after any encoded bytes
    assign tail_term = !state.string_finished && (ended || fin);
    assign nb        = use_enc ? enc.count : 3'd0;

    // Lay out the burst slots
    always_comb
    begin
        burst = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (i < 4 && CNT_W'(i) < nb) begin
                burst.bytes[i] = enc.bytes[i[1:0]];
            end else if (CNT_W'(i) == nb && tail_term) begin
                burst.err[i]  = tail_err;
                burst.term[i] = 1'b1;
            end
        end
        burst.count = nb + CNT_W'(tail_term);
    end

endmodule

`default_nettype wire

// File: rtl/utt_burst.sv
// Result register that shifts a burst of up to five bytes out one transfer at a time.
`default_nettype none

module utt_burst
    import utt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       load,
    input  wire utt_burst_t burst,
    output logic            free,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            error_flag,
    output logic            text_end,
    output logic            run_last
);

    logic [NUM_SLOTS-1:0][7:0] bytes_reg;
    logic [NUM_SLOTS-1:0][7:0] bytes_next;
    logic [NUM_SLOTS-1:0]      err_reg;
    logic [NUM_SLOTS-1:0]      err_next;
    logic [NUM_SLOTS-1:0]      term_reg;
    logic [NUM_SLOTS-1:0]      term_next;
    logic [CNT_W-1:0]          rem_reg;
    logic [CNT_W-1:0]          rem_next;
    logic                      xfer;

    assign out_valid  = (rem_reg != '0);
    assign xfer       = out_valid && out_ready;
    assign free       = (rem_reg == '0) || (rem_reg == CNT_W'(1) && out_ready);
    assign out_byte   = bytes_reg[0];
    assign error_flag = err_reg[0];
    assign text_end   = term_reg[0];
    assign run_last   = (rem_reg == CNT_W'(1));

    // Load a new burst or advance by one slot per transfer
    always_comb
    begin
        bytes_next = bytes_reg;
        err_next   = err_reg;
        term_next  = term_reg;
        rem_next   = rem_reg;
        if (load) begin
            bytes_next = burst.bytes;
            err_next   = burst.err;
            term_next  = burst.term;
            rem_next   = burst.count;
        end else if (xfer) begin
            bytes_next = bytes_reg >> 8;
            err_next   = err_reg >> 1;
            term_next  = term_reg >> 1;
            rem_next   = rem_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rem_reg <= '0;
        end else begin
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
        err_reg   <= err_next;
        term_reg  <= term_next;
    end

endmodule

`default_nettype wire

// File: rtl/utf16_to_utf8_transcoder.sv
// Top level of the UTF-16 to UTF-8 transcoder: input register, string state, result burst.
//
//   channel  handshake              payload
//   input    in_valid / in_ready    code_unit[15:0], final_unit
//   output   out_valid / out_ready  out_byte[7:0], error_flag, text_end, run_last
//
// Each code unit is held in the input register, is decoded and its result bytes
// are loaded into the result register, which sends one byte per cycle while
// out_ready is high. A unit causes one to five results, or none; the result
// register takes the next unit's bytes as the last byte of the previous one transfers.
// The first result of a unit passes through the input register and then the
// result register before it is presented on the output and can transfer.
// rst_n clears the string state and empties both registers; a stalled output
// holds its byte and the input register fills and then drops in_ready.
`default_nettype none

module utf16_to_utf8_transcoder
    import utt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [15:0] code_unit,
    input  wire logic        final_unit,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_byte,
    output logic             error_flag,
    output logic             text_end,
    output logic             run_last
);

    logic        inv_reg;
    logic        inv_next;
    logic [15:0] unit_reg;
    logic        fin_reg;
    utt_state_t  state_reg;
    utt_state_t  state_next;
    utt_state_t  dec_state;
    utt_burst_t  dec_burst;
    logic        burst_free;
    logic        load;

    assign load     = inv_reg && burst_free;
    assign in_ready = !inv_reg || load;

    // Decode the held unit against the string state
    utt_decode u_decode (
        .unit       (unit_reg),
        .fin        (fin_reg),
        .state      (state_reg),
        .burst      (dec_burst),
        .state_next (dec_state)
    );

    // Advance the string state when the unit moves into the result register
    assign state_next = load ? dec_state : state_reg;
    assign inv_next   = (in_valid && in_ready) || (inv_reg && !load);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            inv_reg   <= 1'b0;
            state_reg <= '0;
        end else begin
            inv_reg   <= inv_next;
            state_reg <= state_next;
        end
    end

    // Capture the input payload on each transfer
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            unit_reg <= code_unit;
            fin_reg  <= final_unit;
        end
    end

    utt_burst u_burst (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .burst      (dec_burst),
        .free       (burst_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .error_flag (error_flag),
        .text_end   (text_end),
        .run_last   (run_last)
    );

endmodule

`default_nettype wire

// File: verif/tb_utf16_to_utf8_transcoder.sv
// Self-checking testbench for the UTF-16 to UTF-8 transcoder: directed strings, then random ones.
module tb_utf16_to_utf8_transcoder;
    timeunit 1ns;
    timeprecision 1ps;

    // Surrogate bounds and supplementary plane offset
    localparam logic [15:0] HIGH_FIRST  = 16'hD800;
    localparam logic [15:0] HIGH_LAST   = 16'hDBFF;
    localparam logic [15:0] LOW_FIRST   = 16'hDC00;
    localparam logic [15:0] LOW_LAST    = 16'hDFFF;
    localparam logic [20:0] SUPP_OFFSET = 21'h10000;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_UNITS  = 81;
    localparam int MAX_REPORTED = 10;
    localparam int NUM_DIRECTED = 25;

    typedef struct packed {
        logic [7:0] data;
        logic       err;
        logic       tend;
        logic       last;
    } utf8_res_t;

    typedef struct packed {
        logic [15:0] unit;
        logic        fin;
        logic        typed;
        utf8_res_t   res;
    } stim_row_t;

    localparam utf8_res_t NO_RES    = '{8'h00, 1'b0, 1'b0, 1'b0};
    localparam utf8_res_t TERM_RES  = '{8'h00, 1'b0, 1'b1, 1'b1};
    localparam utf8_res_t ERROR_RES = '{8'h00, 1'b1, 1'b1, 1'b1};

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [15:0] code_unit;
    logic        final_unit;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_byte;
    logic        error_flag;
    logic        text_end;
    logic        run_last;

    // Predictor state: held high surrogate and end-of-text flag
    logic [9:0]  held_bits;
    logic        high_held;
    logic        text_done;

    // Results caused by the unit most recently transcoded
    utf8_res_t   burst [0:4];
    int          burst_n;

    utf8_res_t   utf8_expected [$];
    stim_row_t   directed_rows [0:NUM_DIRECTED-1];

    int src_idle_pct;
    int sink_idle_pct;
    int units_used;
    int units_sent;
    int texts_sent;
    int results_checked;
    int fail_count;
    int cycle_count;

    utf16_to_utf8_transcoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .code_unit  (code_unit),
        .final_unit (final_unit),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .error_flag (error_flag),
        .text_end   (text_end),
        .run_last   (run_last)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Append one result to the current burst
    function automatic void add_result(logic [7:0] d, logic e, logic t);
        burst[burst_n] = '{d, e, t, 1'b0};
        burst_n++;
    endfunction

    // Emit the UTF-8 bytes of one code point
    function automatic void add_code_point(logic [20:0] cp);
        if (cp < 21'h80)
        begin
            add_result(cp[7:0], 1'b0, 1'b0);
        end
        else if (cp < 21'h800)
        begin
            add_result(8'hC0 | 8'(cp >> 6), 1'b0, 1'b0);
            add_result(8'h80 | 8'(cp & 21'h3F), 1'b0, 1'b0);
        end
        else if (cp < 21'h10000)
        begin
            add_result(8'hE0 | 8'(cp >> 12), 1'b0, 1'b0);
            add_result(8'h80 | 8'((cp >> 6) & 21'h3F), 1'b0, 1'b0);
            add_result(8'h80 | 8'(cp & 21'h3F), 1'b0, 1'b0);
        end
        else
        begin
            add_result(8'hF0 | 8'((cp >> 18) & 21'h7), 1'b0, 1'b0);
            add_result(8'h80 | 8'((cp >> 12) & 21'h3F), 1'b0, 1'b0);
            add_result(8'h80 | 8'((cp >> 6) & 21'h3F), 1'b0, 1'b0);
            add_result(8'h80 | 8'(cp & 21'h3F), 1'b0, 1'b0);
        end
    endfunction

    // Transcode one UTF-16 unit into burst[], advancing the string state
    function automatic void transcode_unit(logic [15:0] u, logic f);
        logic is_low;
        logic is_high;
        logic ended;
        is_low  = (u >= LOW_FIRST) && (u <= LOW_LAST);
        is_high = (u >= HIGH_FIRST) && (u <= HIGH_LAST);
        ended   = 1'b0;
        burst_n = 0;

        // Drop everything after the end of text up to the final unit
        if (text_done)
        begin
            if (f)
            begin
                text_done = 1'b0;
                high_held = 1'b0;
                held_bits = '0;
            end
            return;
        end

        if (high_held)
        begin
            high_held = 1'b0;
            if (is_low)
            begin
                add_code_point(21'({held_bits, u[9:0]}) + SUPP_OFFSET);
            end
            else
            begin
                add_result(8'h00, 1'b1, 1'b1);
                ended = 1'b1;
            end
            held_bits = '0;
        end
        else if (u == 16'h0000)
        begin
            add_result(8'h00, 1'b0, 1'b1);
            ended = 1'b1;
        end
        else if (is_low)
        begin
            add_result(8'h00, 1'b1, 1'b1);
            ended = 1'b1;
        end
        else if (is_high)
        begin
            if (f)
            begin
                add_result(8'h00, 1'b1, 1'b1);
                ended = 1'b1;
            end
            else
            begin
                held_bits = u[9:0];
                high_held = 1'b1;
            end
        end
        else
        begin
            add_code_point({5'b0, u});
        end

        // Terminate on the final unit unless already ended
        if (f && !ended)
        begin
            add_result(8'h00, 1'b0, 1'b1);
            ended = 1'b1;
        end
        if (ended && !f)
            text_done = 1'b1;
        if (f)
        begin
            high_held = 1'b0;
            held_bits = '0;
        end
        if (burst_n > 0)
            burst[burst_n-1].last = 1'b1;
    endfunction

    // Present one unit, hold it until the transfer, then queue its expected bytes
    task automatic send_unit(input logic [15:0] u, input logic f,
                             input logic typed, input utf8_res_t typed_res);
        logic was_done;
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        code_unit  <= u;
        final_unit <= f;
        do
            @(posedge clk);
        while (!in_ready);

        was_done = text_done;
        transcode_unit(u, f);
        if (typed)
        begin
            utf8_expected.push_back(typed_res);
        end
        else
        begin
            for (int i = 0; i < burst_n; i++)
                utf8_expected.push_back(burst[i]);
        end
        if (!was_done)
            units_used++;
        units_sent++;
        @(negedge clk);
    endtask

    // Build one random string, mostly well-formed, and send it
    task automatic send_random_text();
        logic [15:0] units [$];
        int          len;
        int          kind;
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
        begin
            kind = $urandom_range(99);
            if (kind < 28)
                units.push_back(16'($urandom_range(1, 16'h7F)));
            else if (kind < 46)
                units.push_back(16'($urandom_range(16'h80, 16'h7FF)));
            else if (kind < 66)
            begin
                if ($urandom_range(1))
                    units.push_back(16'($urandom_range(16'h800, 16'hD7FF)));
                else
                    units.push_back(16'($urandom_range(16'hE000, 16'hFFFF)));
            end
            else if (kind < 86)
            begin
                units.push_back(HIGH_FIRST | 16'($urandom_range(0, 10'h3FF)));
                units.push_back(LOW_FIRST | 16'($urandom_range(0, 10'h3FF)));
            end
            else if (kind < 90)
                units.push_back(HIGH_FIRST | 16'($urandom_range(0, 10'h3FF)));
            else if (kind < 93)
                units.push_back(16'h0000);
            else
                units.push_back(16'($urandom_range(0, 16'hFFFF)));
        end
        foreach (units[i])
            send_unit(units[i], i == units.size() - 1, 1'b0, NO_RES);
        texts_sent++;
    endtask

    // Hold off the sender until every expected byte is back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (utf8_expected.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_phase(input int src_pct, input int sink_pct);
        int target;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        target = units_sent + PHASE_UNITS;
        while (units_sent < target)
            send_random_text();
        drain_results();
    endtask

    task automatic report_mismatch(input string what, input utf8_res_t exp_r,
                                   input utf8_res_t got);
        fail_count++;
        if (fail_count <= MAX_REPORTED)
            $display("mismatch (%s) byte/err/end/last: exp %02h/%0b/%0b/%0b, got %02h/%0b/%0b/%0b",
                     what, exp_r.data, exp_r.err, exp_r.tend, exp_r.last,
                     got.data, got.err, got.tend, got.last);
    endtask

    // Receiver stalls
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= sink_idle_pct);

    // Compare each output transfer with the oldest expectation
    always @(posedge clk)
    begin
        utf8_res_t got;
        utf8_res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{out_byte, error_flag, text_end, run_last};
            if (utf8_expected.size() == 0)
            begin
                report_mismatch("no byte expected", NO_RES, got);
            end
            else
            begin
                want = utf8_expected.pop_front();
                if (got != want)
                    report_mismatch("wrong field", want, got);
                results_checked++;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d bytes outstanding",
                     cycle_count, utf8_expected.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        code_unit       = '0;
        final_unit      = 1'b0;
        out_ready       = 1'b0;
        held_bits       = '0;
        high_held       = 1'b0;
        text_done       = 1'b0;
        burst_n         = 0;
        src_idle_pct    = 32;
        sink_idle_pct   = 54;
        units_used      = 0;
        units_sent      = 0;
        texts_sent      = 0;
        results_checked = 0;
        fail_count      = 0;
        cycle_count     = 0;

        // Directed strings: encoding boundaries, pairs, every surrogate error, drop after end
        directed_rows = '{
            '{16'h0041, 1'b0, 1'b0, NO_RES},
            '{16'h0000, 1'b0, 1'b1, TERM_RES},   // zero unit ends the text
            '{16'h1234, 1'b1, 1'b0, NO_RES},     // dropped, clears the end flag
            '{16'h007F, 1'b0, 1'b0, NO_RES},
            '{16'h0080, 1'b0, 1'b0, NO_RES},
            '{16'h07FF, 1'b0, 1'b0, NO_RES},
            '{16'h0800, 1'b0, 1'b0, NO_RES},
            '{16'hFFFF, 1'b0, 1'b0, NO_RES},
            '{16'hD800, 1'b0, 1'b0, NO_RES},
            '{16'hDC00, 1'b0, 1'b0, NO_RES},     // lowest supplementary point
            '{16'hDBFF, 1'b0, 1'b0, NO_RES},
            '{16'hDFFF, 1'b1, 1'b0, NO_RES},     // pair on the final unit: five bytes
            '{16'hDC00, 1'b0, 1'b1, ERROR_RES},  // lone low surrogate
            '{16'hFFFF, 1'b1, 1'b0, NO_RES},
            '{16'hD800, 1'b0, 1'b0, NO_RES},
            '{16'h0041, 1'b0, 1'b1, ERROR_RES},  // high not followed by low
            '{16'h0000, 1'b1, 1'b0, NO_RES},
            '{16'hDBFF, 1'b1, 1'b1, ERROR_RES},  // high surrogate as final unit
            '{16'h0000, 1'b1, 1'b1, TERM_RES},
            '{16'h0001, 1'b1, 1'b0, NO_RES},
            '{16'hD800, 1'b0, 1'b0, NO_RES},
            '{16'hD800, 1'b0, 1'b1, ERROR_RES},  // high followed by high
            '{16'hFFFF, 1'b1, 1'b0, NO_RES},
            '{16'hDBFF, 1'b0, 1'b0, NO_RES},
            '{16'h0000, 1'b1, 1'b1, ERROR_RES}   // held high, final zero unit
        };

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_unit(directed_rows[i].unit, directed_rows[i].fin,
                      directed_rows[i].typed, directed_rows[i].res);
        drain_results();

        // Random strings under three stall patterns
        run_phase(32, 54);
        run_phase(54, 32);
        run_phase(0, 0);

        // Settle and look for stray bytes
        repeat (16) @(posedge clk);
        fail_count += utf8_expected.size();

        $display("Sent %0d UTF-16 units (%0d transcoded, %0d random strings), checked %0d bytes",
                 units_sent, units_used, texts_sent, results_checked);
        $display("Covered all encoding lengths, surrogate pairs, surrogate errors and drop-after-end");
        if (fail_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("%0d failures", fail_count);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
